>>> rtl/ldv_pkg.sv
// ----------------------------------------------------------------------------
// ldv_pkg: shared types and constants of the Lambert vertex shader
// Item and status structures passed between the front, the queue and the back.
// ----------------------------------------------------------------------------
package ldv_pkg;

    localparam int POS_W      = 32;
    localparam int NRM_W      = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int PROD_W     = POS_W + NRM_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int SUM_W      = 2 * POS_W;
    localparam int LEN_W      = POS_W;
    localparam int REM_W      = LEN_W + 2;
    localparam int SQRT_STEPS = LEN_W;
    localparam int INT_W      = 15;
    localparam int DREM_W     = DOT_W - 1;

    localparam logic signed [DIFF_W-1:0] WIDE_LIMIT = 33'sd2147483647;
    localparam logic [INT_W-1:0]         INTENSITY_MAX = 15'h7fff;

    typedef enum logic [1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } t_cfg_idx;

    // One classified vertex: light vector already halved where it was wide.
    typedef struct packed {
        logic signed [POS_W-1:0] l_x;
        logic signed [POS_W-1:0] l_y;
        logic signed [POS_W-1:0] l_z;
        logic signed [NRM_W-1:0] n_x;
        logic signed [NRM_W-1:0] n_y;
        logic signed [NRM_W-1:0] n_z;
        logic                    zero;
        logic                    last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic                    zero;
        logic                    last;
    } t_side;

endpackage

>>> rtl/ldv_front.sv
// ----------------------------------------------------------------------------
// ldv_front: vertex classification
// Forms the light vector, flags a coincident light and halves wide vectors.
// ----------------------------------------------------------------------------
module ldv_front (
    input  logic signed [ldv_pkg::POS_W-1:0] i_light_x,
    input  logic signed [ldv_pkg::POS_W-1:0] i_light_y,
    input  logic signed [ldv_pkg::POS_W-1:0] i_light_z,
    input  logic signed [ldv_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [ldv_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [ldv_pkg::POS_W-1:0] i_pos_z,
    input  logic signed [ldv_pkg::NRM_W-1:0] i_normal_x,
    input  logic signed [ldv_pkg::NRM_W-1:0] i_normal_y,
    input  logic signed [ldv_pkg::NRM_W-1:0] i_normal_z,
    input  logic                             i_last_vertex,
    output ldv_pkg::t_item                   o_item
);
    import ldv_pkg::*;

    logic signed [DIFF_W-1:0] w_dx, w_dy, w_dz;
    logic signed [DIFF_W-1:0] w_hx, w_hy, w_hz;
    logic                     w_wide;

    assign w_dx = DIFF_W'(i_light_x) - DIFF_W'(i_pos_x);
    assign w_dy = DIFF_W'(i_light_y) - DIFF_W'(i_pos_y);
    assign w_dz = DIFF_W'(i_light_z) - DIFF_W'(i_pos_z);

    assign w_wide = (w_dx > WIDE_LIMIT) || (w_dx < -WIDE_LIMIT) ||
                    (w_dy > WIDE_LIMIT) || (w_dy < -WIDE_LIMIT) ||
                    (w_dz > WIDE_LIMIT) || (w_dz < -WIDE_LIMIT);

    // Arithmetic shift rounds toward minus infinity.
    assign w_hx = w_wide ? (w_dx >>> 1) : w_dx;
    assign w_hy = w_wide ? (w_dy >>> 1) : w_dy;
    assign w_hz = w_wide ? (w_dz >>> 1) : w_dz;

    always_comb begin
        o_item.l_x  = w_hx[POS_W-1:0];
        o_item.l_y  = w_hy[POS_W-1:0];
        o_item.l_z  = w_hz[POS_W-1:0];
        o_item.n_x  = i_normal_x;
        o_item.n_y  = i_normal_y;
        o_item.n_z  = i_normal_z;
        o_item.zero = (w_dx == '0) && (w_dy == '0) && (w_dz == '0);
        o_item.last = i_last_vertex;
    end

endmodule

>>> rtl/ldv_queue.sv
// ----------------------------------------------------------------------------
// ldv_queue: decoupling queue between front and back
// A small register FIFO of classified vertices.
// ----------------------------------------------------------------------------
module ldv_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ldv_pkg::t_item        i_item,
    input  logic                  i_pop,
    output ldv_pkg::t_item        o_item,
    output ldv_pkg::t_q_status    o_status
);
    import ldv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full && !i_pop |=> r_count == CNT_W'(DEPTH))
        else $error("queue lost a full entry");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

>>> rtl/ldv_back.sv
// ----------------------------------------------------------------------------
// ldv_back: shading pipeline
// Squares and dot product, pipelined square root, pipelined division, output.
// ----------------------------------------------------------------------------
module ldv_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  ldv_pkg::t_item                   i_item,
    output logic                             o_take,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic [ldv_pkg::INT_W-1:0]        o_intensity,
    output logic                             o_light_on_vertex,
    output logic                             o_last_out
);
    import ldv_pkg::*;

    logic w_en;
    logic r_out_v;

    // The whole pipeline moves whenever the output register can take a result.
    assign w_en    = !r_out_v || i_pop;
    assign o_take  = w_en && i_valid;
    assign o_empty = !r_out_v;

    // Stage 1: squares and normal products.
    logic signed [SUM_W-1:0]  w_sq_x, w_sq_y, w_sq_z;
    logic signed [PROD_W-1:0] w_dp_x, w_dp_y, w_dp_z;
    logic                     r_s1_v;
    logic [SUM_W-1:0]         r_sq_x, r_sq_y, r_sq_z;
    logic signed [PROD_W-1:0] r_dp_x, r_dp_y, r_dp_z;
    logic                     r_s1_zero, r_s1_last;

    assign w_sq_x = i_item.l_x * i_item.l_x;
    assign w_sq_y = i_item.l_y * i_item.l_y;
    assign w_sq_z = i_item.l_z * i_item.l_z;
    assign w_dp_x = i_item.n_x * i_item.l_x;
    assign w_dp_y = i_item.n_y * i_item.l_y;
    assign w_dp_z = i_item.n_z * i_item.l_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_x    <= $unsigned(w_sq_x);
            r_sq_y    <= $unsigned(w_sq_y);
            r_sq_z    <= $unsigned(w_sq_z);
            r_dp_x    <= w_dp_x;
            r_dp_y    <= w_dp_y;
            r_dp_z    <= w_dp_z;
            r_s1_zero <= i_item.zero;
            r_s1_last <= i_item.last;
        end
    end

    // Stage 2: sums.
    logic             r_s2_v;
    logic [SUM_W-1:0] r_s2_sum;
    t_side            r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_sum       <= r_sq_x + r_sq_y + r_sq_z;
            r_s2_side.dot  <= DOT_W'(r_dp_x) + DOT_W'(r_dp_y) + DOT_W'(r_dp_z);
            r_s2_side.zero <= r_s1_zero;
            r_s2_side.last <= r_s1_last;
        end
    end

    // Square root, one result bit per stage.
    logic             r_sr_v    [SQRT_STEPS];
    logic [SUM_W-1:0] r_sr_s    [SQRT_STEPS];
    logic [REM_W-1:0] r_sr_rem  [SQRT_STEPS];
    logic [LEN_W-1:0] r_sr_root [SQRT_STEPS];
    t_side            r_sr_side [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic             w_v;
        logic [SUM_W-1:0] w_s;
        logic [REM_W-1:0] w_rem;
        logic [LEN_W-1:0] w_root;
        t_side            w_side;
        logic [REM_W+1:0] w_rsh;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_v    = r_s2_v;
            assign w_s    = r_s2_sum;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = r_s2_side;
        end else begin : g_next
            assign w_v    = r_sr_v[k-1];
            assign w_s    = r_sr_s[k-1];
            assign w_rem  = r_sr_rem[k-1];
            assign w_root = r_sr_root[k-1];
            assign w_side = r_sr_side[k-1];
        end

        assign w_rsh   = {w_rem, w_s[SUM_W-1 -: 2]};
        assign w_trial = (REM_W+2)'({w_root, 2'b01});
        assign w_ge    = (w_rsh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sr_v[k] <= 1'b0;
            end else if (w_en) begin
                r_sr_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sr_s[k]    <= {w_s[SUM_W-3:0], 2'b00};
                r_sr_rem[k]  <= w_ge ? REM_W'(w_rsh - w_trial) : REM_W'(w_rsh);
                r_sr_root[k] <= {w_root[LEN_W-2:0], w_ge};
                r_sr_side[k] <= w_side;
            end
        end
    end

    // Division set-up: saturation test and sign checks.
    logic              r_d0_v, r_d0_sat, r_d0_pos, r_d0_zero, r_d0_last;
    logic [DREM_W-1:0] r_d0_rem;
    logic [LEN_W-1:0]  r_d0_len;
    logic [LEN_W-1:0]  w_len;
    t_side             w_sside;

    assign w_len   = r_sr_root[SQRT_STEPS-1];
    assign w_sside = r_sr_side[SQRT_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_v <= 1'b0;
        end else if (w_en) begin
            r_d0_v <= r_sr_v[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0_rem  <= DREM_W'(w_sside.dot);
            r_d0_len  <= w_len;
            r_d0_sat  <= DREM_W'(w_sside.dot) >= (DREM_W'(w_len) << INT_W);
            r_d0_pos  <= (w_sside.dot > 0) && (w_len != '0) && !w_sside.zero;
            r_d0_zero <= w_sside.zero;
            r_d0_last <= w_sside.last;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    logic              r_dv_v    [INT_W];
    logic [DREM_W-1:0] r_dv_rem  [INT_W];
    logic [LEN_W-1:0]  r_dv_len  [INT_W];
    logic [INT_W-1:0]  r_dv_q    [INT_W];
    logic              r_dv_sat  [INT_W];
    logic              r_dv_pos  [INT_W];
    logic              r_dv_zero [INT_W];
    logic              r_dv_last [INT_W];

    for (genvar j = 0; j < INT_W; j++) begin : g_div
        localparam int BIT = INT_W - 1 - j;
        logic              w_v, w_sat, w_pos, w_zero, w_last, w_ge;
        logic [DREM_W-1:0] w_rem, w_trial;
        logic [LEN_W-1:0]  w_l;
        logic [INT_W-1:0]  w_q;

        if (j == 0) begin : g_first
            assign w_v    = r_d0_v;
            assign w_rem  = r_d0_rem;
            assign w_l    = r_d0_len;
            assign w_q    = '0;
            assign w_sat  = r_d0_sat;
            assign w_pos  = r_d0_pos;
            assign w_zero = r_d0_zero;
            assign w_last = r_d0_last;
        end else begin : g_next
            assign w_v    = r_dv_v[j-1];
            assign w_rem  = r_dv_rem[j-1];
            assign w_l    = r_dv_len[j-1];
            assign w_q    = r_dv_q[j-1];
            assign w_sat  = r_dv_sat[j-1];
            assign w_pos  = r_dv_pos[j-1];
            assign w_zero = r_dv_zero[j-1];
            assign w_last = r_dv_last[j-1];
        end

        assign w_trial = DREM_W'(w_l) << BIT;
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[j]  <= w_ge ? (w_rem - w_trial) : w_rem;
                r_dv_len[j]  <= w_l;
                r_dv_q[j]    <= w_q | (INT_W'(w_ge) << BIT);
                r_dv_sat[j]  <= w_sat;
                r_dv_pos[j]  <= w_pos;
                r_dv_zero[j] <= w_zero;
                r_dv_last[j] <= w_last;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_dv_v[INT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_dv_pos[INT_W-1]) begin
                o_intensity <= '0;
            end else if (r_dv_sat[INT_W-1]) begin
                o_intensity <= INTENSITY_MAX;
            end else begin
                o_intensity <= r_dv_q[INT_W-1];
            end
            o_light_on_vertex <= r_dv_zero[INT_W-1];
            o_last_out        <= r_dv_last[INT_W-1];
        end
    end

endmodule

>>> rtl/lambert_diffuse_vertex_shade.sv
// ----------------------------------------------------------------------------
// lambert_diffuse_vertex_shade: point light Lambert shading of vertices
// Top level: light registers, classification front, queue and shading back.
// ----------------------------------------------------------------------------
// The block takes one vertex in every cycle while the queue is not full and
// gives one white unsigned Q1.14 intensity per vertex, in order. From its
// transfer in to its result a vertex passes the decoupling queue, the squares
// and the sums, the square root stages (one root bit per stage), the saturation
// test, the division stages (one quotient bit per stage) and the output
// register. While results are not taken the back pipeline holds as a whole
// and the queue keeps accepting vertices until it fills.
module lambert_diffuse_vertex_shade #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    // Vertex input queue side.
    input  logic                             push,
    output logic                             full,
    input  logic signed [ldv_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [ldv_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [ldv_pkg::POS_W-1:0] i_pos_z,
    input  logic signed [ldv_pkg::NRM_W-1:0] i_normal_x,
    input  logic signed [ldv_pkg::NRM_W-1:0] i_normal_y,
    input  logic signed [ldv_pkg::NRM_W-1:0] i_normal_z,
    input  logic                             i_last_vertex,
    // Result queue side.
    output logic                             empty,
    input  logic                             pop,
    output logic [ldv_pkg::INT_W-1:0]        o_intensity,
    output logic                             o_light_on_vertex,
    output logic                             o_last_out
);
    import ldv_pkg::*;

    logic signed [POS_W-1:0] r_light_x, r_light_y, r_light_z;
    t_item                   w_front_item, w_q_item;
    t_q_status               w_q_status;
    logic                    w_push, w_take;

    // Writes are always taken; an index past the last register is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LIGHT_X: r_light_x <= i_cfg_data;
                CFG_LIGHT_Y: r_light_y <= i_cfg_data;
                CFG_LIGHT_Z: r_light_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign full   = w_q_status.full;
    assign w_push = push && !w_q_status.full;

    ldv_front u_front (
        .i_light_x    (r_light_x),
        .i_light_y    (r_light_y),
        .i_light_z    (r_light_z),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_normal_x   (i_normal_x),
        .i_normal_y   (i_normal_y),
        .i_normal_z   (i_normal_z),
        .i_last_vertex(i_last_vertex),
        .o_item       (w_front_item)
    );

    ldv_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_take),
        .o_item  (w_q_item),
        .o_status(w_q_status)
    );

    ldv_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (!w_q_status.empty),
        .i_item           (w_q_item),
        .o_take           (w_take),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_intensity      (o_intensity),
        .o_light_on_vertex(o_light_on_vertex),
        .o_last_out       (o_last_out)
    );

    // A coincident light must never produce a non-zero intensity.
    a_on_vertex_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_light_on_vertex |-> o_intensity == '0)
        else $error("light on vertex with non-zero intensity");
    // Reset leaves both queue sides empty.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("reset did not clear the block");
    // The back only draws from the queue while the result side can move.
    a_take_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> empty || pop)
        else $error("vertex taken while result stalled");

endmodule
